// ----- hw/rtl/pcicfg_pkg.sv -----
// Package for the PCI configuration space emulator.
// Holds widths, header constants and the reset image of the word store.
// No dependencies.
package pcicfg_pkg;

  localparam int unsigned StoreWordsDef = 64;
  localparam int unsigned IdxW          = 6;   // register index, address bits 7..2
  localparam int unsigned DataW         = 32;

  localparam logic [0:0] OpRead  = 1'b0;
  localparam logic [0:0] OpWrite = 1'b1;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;

  localparam logic [1:0] CfgBus  = 2'd0;
  localparam logic [1:0] CfgDev  = 2'd1;
  localparam logic [1:0] CfgFunc = 2'd2;

  localparam logic [DataW-1:0] FillWord  = 32'hBADC_0FFE;
  localparam logic [DataW-1:0] HdrWord0  = 32'hBEEF_F00D;
  localparam logic [DataW-1:0] HdrWord1  = 32'h0010_0001;
  localparam logic [DataW-1:0] HdrWord2  = 32'hFF00_0000;
  localparam logic [DataW-1:0] HdrWord13 = 32'h0000_0050;
  localparam logic [DataW-1:0] HdrWord20 = 32'h0001_0005;

  // Value a word holds until first written
  function automatic logic [DataW-1:0] reset_word(input logic [IdxW-1:0] idx);
    logic [DataW-1:0] w;
    w = FillWord;
    priority if (idx == 6'd0)  w = HdrWord0;
    else if (idx == 6'd1)      w = HdrWord1;
    else if (idx == 6'd2)      w = HdrWord2;
    else if (idx <= 6'd12)     w = '0;
    else if (idx == 6'd13)     w = HdrWord13;
    else if (idx <= 6'd15)     w = '0;
    else if (idx == 6'd20)     w = HdrWord20;
    else if (idx >= 6'd21 && idx <= 6'd24) w = '0;
    else                       w = FillWord;
    return w;
  endfunction

endpackage

// ----- hw/rtl/pci_config_space_emulator.sv -----
// Top level of the PCI configuration space emulator (CF8/CFC mechanism).
// Depends on pcicfg_pkg; holds the word store and its read-modify-write path.
//
// One data-port request runs as follows: start is taken when busy is low, the
// store is read at that edge, the next cycle (busy high) merges and writes the
// word back, and done strobes the result for one cycle after that. A new request
// can be taken in the cycle done is high but not while busy is high, since the
// registered read of the store is followed by its write-back. The result must be
// taken when done is high; it is not held. The store needs no clearing pass after
// reset: a valid bit per word marks written words; the others read their header
// value. Bus/device/function writes are taken at any time but are meant for an
// idle block.
module pci_config_space_emulator
  import pcicfg_pkg::*;
#(
  parameter int unsigned StoreWords = StoreWordsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             op_i,
  input  logic [31:0]      config_address_i,
  input  logic [1:0]       port_offset_i,
  input  logic [1:0]       access_size_i,
  input  logic [31:0]      write_data_i,
  output logic             done_o,
  output logic [31:0]      read_data_o,
  output logic             emulated_o
);

  localparam int unsigned AddrW = (StoreWords > 1) ? $clog2(StoreWords) : 1;

  // configuration registers
  logic [7:0] bus_q;
  logic [4:0] dev_q;
  logic [2:0] func_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q  <= '0;
      dev_q  <= '0;
      func_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgBus:  bus_q  <= cfg_wdata_i;
        CfgDev:  dev_q  <= cfg_wdata_i[4:0];
        CfgFunc: func_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic             accept;
  logic             busy_q;
  logic             op_q;
  logic [23:0]      addr_hi_q;
  logic [IdxW-1:0]  idx_q;
  logic [1:0]       offset_q;
  logic [1:0]       size_q;
  logic [31:0]      wdata_q;
  logic [IdxW-1:0]  idx_in;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;
  assign idx_in = config_address_i[7:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_i;
      addr_hi_q <= config_address_i[31:8];
      idx_q     <= idx_in;
      offset_q  <= port_offset_i;
      size_q    <= access_size_i;
      wdata_q   <= write_data_i;
    end
  end

  // word store, registered read at accept, write-back in the busy cycle
  logic [31:0]           mem [StoreWords];
  logic [31:0]           rd_q;
  logic [StoreWords-1:0] valid_q;
  logic                  wr_en;
  logic [31:0]           wr_word;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[idx_in[AddrW-1:0]];
    end
    if (wr_en) begin
      mem[idx_q[AddrW-1:0]] <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[idx_q[AddrW-1:0]] <= 1'b1;
    end
  end

  // modify stage
  logic [23:0] base;
  logic        match;
  logic        in_range;
  logic [31:0] old_word;
  logic [31:0] shifted;
  logic [31:0] rdata_d;
  logic        emu_d;

  assign base     = {8'h80, bus_q, dev_q, func_q};
  assign match    = (addr_hi_q == base);
  assign in_range = ({1'b0, idx_q} < (IdxW + 1)'(StoreWords));

  always_comb begin
    old_word = FillWord;
    if (in_range) begin
      old_word = valid_q[idx_q[AddrW-1:0]] ? rd_q : reset_word(idx_q);
    end
  end

  assign shifted = old_word >> {offset_q, 3'b000};

  always_comb begin
    rdata_d = '0;
    emu_d   = 1'b0;
    wr_word = wdata_q;
    wr_en   = 1'b0;
    if (op_q == OpRead) begin
      if (match) begin
        emu_d = 1'b1;
        unique case (size_q)
          SizeByte: rdata_d = {24'h0, shifted[7:0]};
          SizeHalf: rdata_d = {16'h0, shifted[15:0]};
          default:  rdata_d = shifted;
        endcase
      end
    end else if (match && offset_q == 2'd0) begin
      emu_d = 1'b1;
      unique case (size_q)
        SizeByte: wr_word = {old_word[31:8], wdata_q[7:0]};
        SizeHalf: wr_word = {old_word[31:16], wdata_q[15:0]};
        default:  wr_word = wdata_q;
      endcase
      wr_en = busy_q && in_range;  // out-of-range writes are dropped
    end
  end

  // result register
  logic        done_q;
  logic [31:0] rdata_q;
  logic        emu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rdata_q <= rdata_d;
      emu_q   <= emu_d;
    end
  end

  assign done_o      = done_q;
  assign read_data_o = rdata_q;
  assign emulated_o  = emu_q;

  // checks
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without a busy cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o)) else $error("request not taken up");

  a_busy_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (!busy_o && done_o)) else $error("busy longer than one cycle");

  a_fwd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !emulated_o) |-> (read_data_o == '0)) else $error("forwarded request with data");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for pci_config_space_emulator: directed and random data-port requests,
// each checked against a local model of the window match and the word store.
// Depends on pcicfg_pkg and the emulator RTL.
module tb;
  import pcicfg_pkg::*;

  localparam logic [1:0] SizeWord  = 2'd2;
  localparam logic [1:0] SizeWide  = 2'd3;   // decodes as a full word
  localparam int unsigned QuietLimit = 1000;

  typedef struct packed {
    logic [31:0] read_data;
    logic        emulated;
  } cfg_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgBus;
  logic [7:0]  cfg_wdata_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        op_i = OpRead;
  logic [31:0] config_address_i = '0;
  logic [1:0]  port_offset_i = '0;
  logic [1:0]  access_size_i = '0;
  logic [31:0] write_data_i = '0;
  logic        done_o;
  logic [31:0] read_data_o;
  logic        emulated_o;

  // shadow of the block's state
  logic [31:0] shadow_space [StoreWordsDef];
  logic [7:0]  win_bus = '0;
  logic [4:0]  win_dev = '0;
  logic [2:0]  win_fn = '0;

  cfg_result_t expected_results [$];
  int fail_count = 0;
  int n_requests = 0;
  int n_emu_reads = 0;
  int n_emu_writes = 0;
  int n_forwarded = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  pci_config_space_emulator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .config_address_i (config_address_i),
    .port_offset_i    (port_offset_i),
    .access_size_i    (access_size_i),
    .write_data_i     (write_data_i),
    .done_o           (done_o),
    .read_data_o      (read_data_o),
    .emulated_o       (emulated_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] window_base();
    return {1'b1, 7'b0, win_bus, win_dev, win_fn, 8'h00};
  endfunction

  function automatic void load_header_image();
    for (int i = 0; i < StoreWordsDef; i++) begin
      if ((i >= 3 && i <= 12) || i == 14 || i == 15 || (i >= 21 && i <= 24)) begin
        shadow_space[i] = '0;
      end else begin
        shadow_space[i] = FillWord;
      end
    end
    shadow_space[0]  = HdrWord0;
    shadow_space[1]  = HdrWord1;
    shadow_space[2]  = HdrWord2;
    shadow_space[13] = HdrWord13;
    shadow_space[20] = HdrWord20;
  endfunction

  // Serves one request against the shadow store; updates it on an emulated write
  function automatic cfg_result_t emulate_access(logic op, logic [31:0] addr,
                                                 logic [1:0] off, logic [1:0] size,
                                                 logic [31:0] wdata);
    cfg_result_t res;
    logic [5:0]  idx;
    logic [31:0] word;
    logic [31:0] wbase;
    logic        hit;
    res   = '0;
    idx   = addr[7:2];
    wbase = window_base();
    hit   = (addr[31:8] == wbase[31:8]);
    word  = (idx < StoreWordsDef) ? shadow_space[idx] : FillWord;
    if (op == OpRead) begin
      if (hit) begin
        word = word >> (8 * off);
        if (size == SizeByte) word = {24'h0, word[7:0]};
        else if (size == SizeHalf) word = {16'h0, word[15:0]};
        res.read_data = word;
        res.emulated  = 1'b1;
        n_emu_reads++;
      end else begin
        n_forwarded++;
      end
    end else if (hit && off == 2'd0) begin
      if (size == SizeByte) word = {word[31:8], wdata[7:0]};
      else if (size == SizeHalf) word = {word[31:16], wdata[15:0]};
      else word = wdata;
      if (idx < StoreWordsDef) shadow_space[idx] = word;
      res.emulated = 1'b1;
      n_emu_writes++;
    end else begin
      n_forwarded++;
    end
    return res;
  endfunction

  // Issues one request; returns in the step it is taken, start still high
  // unless an idle gap follows.
  task automatic issue_access(logic op, logic [31:0] addr, logic [1:0] off,
                              logic [1:0] size, logic [31:0] wdata);
    start_i          <= 1'b1;
    op_i             <= op;
    config_address_i <= addr;
    port_offset_i    <= off;
    access_size_i    <= size;
    write_data_i     <= wdata;
    do @(posedge clk_i); while (busy_o);
    expected_results.push_back(emulate_access(op, addr, off, size, wdata));
    n_requests++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do begin
        // junk on the fields while start is low
        op_i             <= 1'($urandom_range(1));
        config_address_i <= $urandom();
        port_offset_i    <= 2'($urandom_range(3));
        access_size_i    <= 2'($urandom_range(3));
        write_data_i     <= $urandom();
        @(posedge clk_i);
      end while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain_requests();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgBus:  win_bus = data;
      CfgDev:  win_dev = data[4:0];
      CfgFunc: win_fn  = data[2:0];
      default: ;
    endcase
  endtask

  // Only called with the block idle; unused upper bits carry junk
  task automatic set_window(logic [7:0] bus, logic [4:0] dev, logic [2:0] fn);
    write_cfg(CfgBus, bus);
    write_cfg(CfgDev, {3'($urandom_range(7)), dev});
    write_cfg(CfgFunc, {5'($urandom_range(31)), fn});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_header_reads();
    logic [31:0] base;
    base = window_base();
    issue_access(OpRead, base, 2'd0, SizeWord, $urandom());
    issue_access(OpRead, base, 2'd3, SizeByte, $urandom());
    issue_access(OpRead, base, 2'd2, SizeHalf, $urandom());
    issue_access(OpRead, base, 2'd3, SizeHalf, $urandom());
    issue_access(OpRead, base | (20 << 2), 2'd1, SizeWide, $urandom());
    issue_access(OpRead, base | (13 << 2) | 32'h3, 2'd0, SizeWord, $urandom());
    issue_access(OpRead, base | 32'hFC, 2'd1, SizeWord, $urandom());
    drain_requests();
  endtask

  task automatic test_write_merge();
    logic [31:0] base;
    base = window_base();
    issue_access(OpWrite, base | (3 << 2), 2'd0, SizeByte, 32'hFFFF_FFAA);
    issue_access(OpWrite, base | (3 << 2), 2'd0, SizeHalf, 32'h1234_5678);
    issue_access(OpRead, base | (3 << 2), 2'd0, SizeWord, '0);
    issue_access(OpWrite, base | (3 << 2), 2'd0, SizeWide, 32'hFFFF_FFFF);
    issue_access(OpWrite, base | 32'hFF, 2'd0, SizeWord, 32'h0000_0000);
    issue_access(OpRead, base | 32'hFC, 2'd0, SizeWord, 32'hFFFF_FFFF);
    issue_access(OpRead, base | (3 << 2), 2'd1, SizeWide, '0);
    drain_requests();
  endtask

  task automatic test_forwarding();
    logic [31:0] base;
    base = window_base();
    issue_access(OpWrite, base | (4 << 2), 2'd1, SizeByte, 32'hFFFF_FFFF);
    issue_access(OpWrite, base | (4 << 2), 2'd3, SizeWord, 32'hFFFF_FFFF);
    issue_access(OpRead, base & 32'h7FFF_FFFF, 2'd0, SizeWord, '0);
    issue_access(OpRead, base | 32'h4000_0000, 2'd0, SizeWord, '0);
    issue_access(OpWrite, base | 32'h0100_0000 | (4 << 2), 2'd0, SizeWord, 32'hFFFF_FFFF);
    issue_access(OpRead, base | (4 << 2), 2'd0, SizeWord, '0);
    drain_requests();
  endtask

  task automatic test_function_window();
    logic [31:0] old_base;
    old_base = window_base();
    set_window(8'hFF, 5'h1F, 3'h7);
    issue_access(OpRead, old_base, 2'd0, SizeWord, '0);
    issue_access(OpWrite, window_base() | (5 << 2), 2'd0, SizeWord, 32'hA5A5_5A5A);
    issue_access(OpRead, window_base() | (5 << 2), 2'd2, SizeHalf, '0);
    issue_access(OpRead, window_base() ^ 32'h0000_0100, 2'd0, SizeWord, '0);
    drain_requests();
  endtask

  // Mostly hits in the window; the rest near misses on one address bit or noise
  task automatic test_random_traffic(int n, int pct);
    logic [31:0] addr;
    logic [1:0]  off;
    int          pick;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      addr = window_base() | 32'($urandom_range(255));
      if (pick >= 90) addr = $urandom();
      else if (pick >= 75) addr = addr ^ (32'h100 << $urandom_range(23));
      off = ($urandom_range(1) != 0) ? 2'd0 : 2'($urandom_range(3));
      issue_access(($urandom_range(1) != 0) ? OpWrite : OpRead, addr, off,
                   2'($urandom_range(3)), $urandom());
      if ($urandom_range(199) == 0) drain_requests();
    end
    drain_requests();
    idle_pct = 0;
  endtask

  always @(posedge clk_i) begin
    cfg_result_t exp_res;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: read_data %h emulated %b",
               read_data_o, emulated_o);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (read_data_o !== exp_res.read_data) begin
          $error("read_data: expected %h, got %h", exp_res.read_data, read_data_o);
          fail_count++;
        end
        if (emulated_o !== exp_res.emulated) begin
          $error("emulated: expected %b, got %b", exp_res.emulated, emulated_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no progress for %0d cycles", QuietLimit);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    load_header_image();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_reads();
    test_write_merge();
    test_forwarding();
    test_function_window();

    set_window(8'h00, 5'h00, 3'h0);
    test_random_traffic(350, 0);
    set_window(8'hFF, 5'h1F, 3'h7);
    test_random_traffic(350, 72);
    set_window(8'($urandom_range(255)), 5'($urandom_range(31)), 3'($urandom_range(7)));
    test_random_traffic(350, 33);
    set_window(8'($urandom_range(255)), 5'($urandom_range(31)), 3'($urandom_range(7)));
    test_random_traffic(350, 0);

    drain_requests();
    repeat (4) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end

    $display("%0d requests: %0d emulated reads, %0d emulated writes, %0d forwarded",
             n_requests, n_emu_reads, n_emu_writes, n_forwarded);
    $display("window at both extremes and two random spots, sender idle 0/72/33 pct");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
